/* src/mssfc_pkg.sv */
// Shared constants for the motor start/stop/fault controller.
package mssfc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned DEB_W  = 8;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_BTN = 3;

  // Button slots
  localparam int unsigned BTN_START = 0;
  localparam int unsigned BTN_STOP  = 1;
  localparam int unsigned BTN_FAULT = 2;

  // Mode codes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_FAULT = 2'd2;

  // LED colour codes
  localparam logic [1:0] COL_OFF    = 2'd0;
  localparam logic [1:0] COL_RED    = 2'd1;
  localparam logic [1:0] COL_GREEN  = 2'd2;
  localparam logic [1:0] COL_YELLOW = 2'd3;

  // Beep counts
  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_ONE   = 2'd1;
  localparam logic [1:0] BEEP_TWO   = 2'd2;
  localparam logic [1:0] BEEP_THREE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_HOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_BLINK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_BLINK = 3'd4;

  // Register reset values
  localparam logic [DEB_W-1:0]  DEBOUNCE_DEF   = 8'd50;
  localparam logic [TIME_W-1:0] START_HOLD_DEF = 16'd3000;
  localparam logic [TIME_W-1:0] CLEAR_HOLD_DEF = 16'd5000;
  localparam logic [TIME_W-1:0] SLOW_BLINK_DEF = 16'd500;
  localparam logic [TIME_W-1:0] FAST_BLINK_DEF = 16'd100;

endpackage

/* src/mssfc_debounce.sv */
// Debouncer for one active-low button: saturating count of unchanged ticks.
module mssfc_debounce
  import mssfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             level_i,
  input  logic [DEB_W-1:0] debounce_ticks_i,
  output logic             pressed_o
);

  localparam logic [DEB_W-1:0] CntMax = {DEB_W{1'b1}};

  logic             last_q, last_d;
  logic [DEB_W-1:0] cnt_q, cnt_d;
  logic             pressed_q, pressed_d;

  always_comb begin
    if (level_i != last_q) begin
      cnt_d = '0;
    end else if (cnt_q != CntMax) begin
      cnt_d = cnt_q + DEB_W'(1);
    end else begin
      cnt_d = cnt_q;
    end
    // a saturated count counts as settled
    if (cnt_d > debounce_ticks_i || cnt_d == CntMax) begin
      pressed_d = ~level_i;
    end else begin
      pressed_d = pressed_q;
    end
    last_d = level_i;
  end

  assign pressed_o = pressed_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b1;
      cnt_q     <= '0;
      pressed_q <= 1'b0;
    end else if (en_i) begin
      last_q    <= last_d;
      cnt_q     <= cnt_d;
      pressed_q <= pressed_d;
    end
  end

endmodule

/* src/motor_start_stop_fault_controller.sv */
// Top level of the motor start/stop/fault controller.
// Each input item is one millisecond tick of raw start/stop/fault levels
// (active low); each item yields exactly one result with relay drive, LED
// colour, beep count, mode and the fault flag. An item is captured in an
// input register and the whole state update runs combinationally from there
// into the result register, so a result is offered once its item leaves the
// input register, and one item is accepted per clock cycle sustained, limited
// only by the result side taking items. Configuration writes are always
// taken at once. Hold and blink timers saturate at 2^COUNT_WIDTH-1.
// No clearing pass.
module motor_start_stop_fault_controller
  import mssfc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  start_level_i,
  input  logic                  stop_level_i,
  input  logic                  fault_level_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  motor_on_o,
  output logic [1:0]            led_colour_o,
  output logic [1:0]            beep_pattern_o,
  output logic [1:0]            mode_o,
  output logic                  fault_saved_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW    = COUNT_WIDTH;
  localparam int unsigned CMP_W = (CW > TIME_W) ? CW : TIME_W;
  localparam logic [CW-1:0] CntMax = {CW{1'b1}};

  // Configuration registers
  logic [DEB_W-1:0]  debounce_q;
  logic [TIME_W-1:0] start_hold_q, clear_hold_q, slow_blink_q, fast_blink_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_DEF;
      start_hold_q <= START_HOLD_DEF;
      clear_hold_q <= CLEAR_HOLD_DEF;
      slow_blink_q <= SLOW_BLINK_DEF;
      fast_blink_q <= FAST_BLINK_DEF;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE:   debounce_q   <= cfg_data_i[DEB_W-1:0];
        REG_START_HOLD: start_hold_q <= cfg_data_i;
        REG_CLEAR_HOLD: clear_hold_q <= cfg_data_i;
        REG_SLOW_BLINK: slow_blink_q <= cfg_data_i;
        REG_FAST_BLINK: fast_blink_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage and result stage handshake
  logic               in_valid_q, out_valid_q, proc_go;
  logic [NUM_BTN-1:0] level_q;

  assign proc_go    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (proc_go) begin
        in_valid_q <= 1'b0;
      end
      if (proc_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      level_q <= {fault_level_i, stop_level_i, start_level_i};
    end
  end

  // Debounced press state, next values
  logic [NUM_BTN-1:0] pr;

  for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
    mssfc_debounce u_deb (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .en_i             (proc_go),
      .level_i          (level_q[b]),
      .debounce_ticks_i (debounce_q),
      .pressed_o        (pr[b])
    );
  end

  // Controller state
  logic [1:0]         mode_q, mode_d;
  logic [NUM_BTN-1:0] ha_q, ha_d;
  logic [CW-1:0]      hc_q [NUM_BTN];
  logic [CW-1:0]      hc_d [NUM_BTN];
  logic [CW-1:0]      blink_q, blink_d;
  logic               lit_q, lit_d;
  logic [1:0]         colour_q, colour_d;
  logic               start_blk_q, start_blk_d;
  logic               stop_blk_q, stop_blk_d;
  logic               clearing_q, clearing_d;
  logic               fast_q, fast_d;
  logic               fflag_q, fflag_d;
  logic [1:0]         beep_d;

  logic              start_done, stop_done, clear_done, blink_on;
  logic [TIME_W-1:0] period;

  always_comb begin
    for (int b = 0; b < NUM_BTN; b++) begin
      hc_d[b] = (ha_q[b] && hc_q[b] != CntMax) ? hc_q[b] + CW'(1) : hc_q[b];
    end
    ha_d        = ha_q;
    blink_d     = (blink_q != CntMax) ? blink_q + CW'(1) : blink_q;
    mode_d      = mode_q;
    lit_d       = lit_q;
    colour_d    = colour_q;
    start_blk_d = start_blk_q;
    stop_blk_d  = stop_blk_q;
    clearing_d  = clearing_q;
    fast_d      = fast_q;
    fflag_d     = fflag_q;
    beep_d      = BEEP_NONE;
    start_done  = 1'b0;
    stop_done   = 1'b0;
    clear_done  = 1'b0;
    period      = slow_blink_q;

    case (mode_q)
      MODE_OFF: begin
        if (pr[BTN_START]) begin
          if (!ha_q[BTN_START]) begin
            ha_d[BTN_START] = 1'b1;
            hc_d[BTN_START] = '0;
          end else if (CMP_W'(hc_d[BTN_START]) >= CMP_W'(start_hold_q)) begin
            ha_d[BTN_START] = 1'b0;
            start_done      = 1'b1;
          end
        end else begin
          ha_d[BTN_START] = 1'b0;
        end
        if (start_done) begin
          beep_d      = BEEP_ONE;
          mode_d      = MODE_RUN;
          colour_d    = COL_GREEN;
          start_blk_d = 1'b0;
        end else begin
          start_blk_d = pr[BTN_START] && ha_d[BTN_START];
          if (!pr[BTN_START]) begin
            colour_d = COL_RED;
          end
        end
      end
      MODE_RUN: begin
        if (pr[BTN_STOP]) begin
          if (!ha_q[BTN_STOP]) begin
            ha_d[BTN_STOP] = 1'b1;
            hc_d[BTN_STOP] = '0;
          end else if (CMP_W'(hc_d[BTN_STOP]) >= CMP_W'(start_hold_q)) begin
            ha_d[BTN_STOP] = 1'b0;
            stop_done      = 1'b1;
          end
        end else begin
          ha_d[BTN_STOP] = 1'b0;
        end
        if (stop_done) begin
          beep_d     = BEEP_TWO;
          mode_d     = MODE_OFF;
          colour_d   = COL_RED;
          stop_blk_d = 1'b0;
        end else begin
          stop_blk_d = pr[BTN_STOP] && ha_d[BTN_STOP];
          if (!pr[BTN_STOP]) begin
            colour_d = COL_GREEN;
          end
        end
        // fault wins over a stop that completes in the same tick
        if (pr[BTN_FAULT]) begin
          beep_d     = BEEP_THREE;
          fflag_d    = 1'b1;
          mode_d     = MODE_FAULT;
          fast_d     = 1'b1;
          blink_d    = '0;
          lit_d      = 1'b0;
          clearing_d = 1'b0;
        end
      end
      MODE_FAULT: begin
        if (pr[BTN_FAULT]) begin
          if (!ha_q[BTN_FAULT]) begin
            ha_d[BTN_FAULT] = 1'b1;
            hc_d[BTN_FAULT] = '0;
          end else if (CMP_W'(hc_d[BTN_FAULT]) >= CMP_W'(clear_hold_q)) begin
            ha_d[BTN_FAULT] = 1'b0;
            clear_done      = 1'b1;
          end
        end else begin
          ha_d[BTN_FAULT] = 1'b0;
        end
        if (clear_done) begin
          beep_d     = BEEP_TWO;
          fflag_d    = 1'b0;
          mode_d     = MODE_OFF;
          colour_d   = COL_RED;
          clearing_d = 1'b0;
        end else begin
          clearing_d = pr[BTN_FAULT] && ha_d[BTN_FAULT];
          fast_d     = !clearing_d;
        end
      end
      default: ;
    endcase

    blink_on = (mode_d == MODE_FAULT) ||
               (mode_d == MODE_OFF && start_blk_d) ||
               (mode_d == MODE_RUN && stop_blk_d);
    if (blink_on || clearing_d) begin
      period = fast_d ? fast_blink_q : slow_blink_q;
      if (CMP_W'(blink_d) >= CMP_W'(period)) begin
        blink_d = '0;
        if (lit_q && lit_d) begin
          colour_d = COL_OFF;
        end else if (lit_d) begin
          colour_d = COL_OFF;
        end else begin
          colour_d = (mode_d == MODE_FAULT) ? COL_RED : COL_YELLOW;
        end
        lit_d = !lit_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OFF;
      ha_q        <= '0;
      for (int b = 0; b < NUM_BTN; b++) begin
        hc_q[b] <= '0;
      end
      blink_q     <= '0;
      lit_q       <= 1'b0;
      colour_q    <= COL_RED;
      start_blk_q <= 1'b0;
      stop_blk_q  <= 1'b0;
      clearing_q  <= 1'b0;
      fast_q      <= 1'b0;
      fflag_q     <= 1'b0;
    end else if (proc_go) begin
      mode_q      <= mode_d;
      ha_q        <= ha_d;
      for (int b = 0; b < NUM_BTN; b++) begin
        hc_q[b] <= hc_d[b];
      end
      blink_q     <= blink_d;
      lit_q       <= lit_d;
      colour_q    <= colour_d;
      start_blk_q <= start_blk_d;
      stop_blk_q  <= stop_blk_d;
      clearing_q  <= clearing_d;
      fast_q      <= fast_d;
      fflag_q     <= fflag_d;
    end
  end

  // Result register
  logic       motor_on_q, fault_saved_q;
  logic [1:0] led_colour_q, beep_q, mode_out_q;

  always_ff @(posedge clk_i) begin
    if (proc_go) begin
      motor_on_q    <= (mode_d == MODE_RUN);
      led_colour_q  <= colour_d;
      beep_q        <= beep_d;
      mode_out_q    <= mode_d;
      fault_saved_q <= fflag_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motor_on_o     = motor_on_q;
  assign led_colour_o   = led_colour_q;
  assign beep_pattern_o = beep_q;
  assign mode_o         = mode_out_q;
  assign fault_saved_o  = fault_saved_q;

`ifndef SYNTHESIS
  // the fault flag is set exactly while the fault mode is latched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fflag_q == (mode_q == MODE_FAULT))
    else $error("fault flag out of step with mode");

  // a processed item always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_go |=> out_valid_q)
    else $error("processed item lost");

  // a waiting input item is held until processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc_go |=> in_valid_q && $stable(level_q))
    else $error("waiting input item dropped or changed");

  // relay drive follows the reported mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (motor_on_q == (mode_out_q == MODE_RUN)))
    else $error("relay drive disagrees with mode");

  // state changes only when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc_go |=> $stable(mode_q) && $stable(colour_q))
    else $error("state moved without an item");
`endif

endmodule

/* bench/motor_ctrl_checker.sv */
// Channel monitor, tick predictor and result comparison for the motor controller.
`timescale 1ns / 100ps

module motor_ctrl_checker
  import mssfc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  start_level_i,
  input  logic                  stop_level_i,
  input  logic                  fault_level_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  motor_on_i,
  input  logic [1:0]            led_colour_i,
  input  logic [1:0]            beep_pattern_i,
  input  logic [1:0]            mode_i,
  input  logic                  fault_saved_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    results_pending_o
);

  typedef struct packed {
    logic       motor_on;
    logic [1:0] led_colour;
    logic [1:0] beep;
    logic [1:0] mode;
    logic       fault_saved;
  } tick_result_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [DEB_W-1:0]       DEB_MAX = '1;

  // register copies
  logic [DEB_W-1:0]  deb_ticks;
  logic [TIME_W-1:0] start_hold;
  logic [TIME_W-1:0] clear_hold;
  logic [TIME_W-1:0] slow_blink;
  logic [TIME_W-1:0] fast_blink;

  // controller state
  logic [1:0]             mode_q;
  logic [NUM_BTN-1:0]     last_lv;
  logic [NUM_BTN-1:0]     btn_down;
  logic [NUM_BTN-1:0]     hold_on;
  logic [DEB_W-1:0]       stable_cnt [NUM_BTN];
  logic [COUNT_WIDTH-1:0] hold_cnt [NUM_BTN];
  logic [COUNT_WIDTH-1:0] blink_cnt;
  logic                   led_lit;
  logic [1:0]             colour_q;
  logic                   start_blink;
  logic                   stop_blink;
  logic                   clearing;
  logic                   fast_sel;
  logic                   fault_flag;

  tick_result_t expected_results [$];
  tick_result_t want;
  int           mismatch_cnt;
  int           results_seen;
  int           b;

  assign mismatch_count_o = mismatch_cnt;

  task automatic report_mismatch(input string what);
    $display("[%0t] result %0d: %s", $time, results_seen, what);
    mismatch_cnt++;
  endtask

  task automatic compare_field(input string name, input int got, input int exp_v);
    if (got != exp_v) begin
      report_mismatch($sformatf("%s is %0d, predicted %0d", name, got, exp_v));
    end
  endtask

  // Return 1 when the hold on button btn has lasted need ticks.
  function automatic logic hold_finished(input int btn, input logic [TIME_W-1:0] need);
    if (btn_down[btn]) begin
      if (!hold_on[btn]) begin
        hold_on[btn]  = 1'b1;
        hold_cnt[btn] = '0;
      end else if (hold_cnt[btn] >= need) begin
        hold_on[btn] = 1'b0;
        return 1'b1;
      end
    end else begin
      hold_on[btn] = 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic tick_result_t predict_tick(input logic [NUM_BTN-1:0] lv);
    tick_result_t      r;
    logic [1:0]        beep;
    logic              blink;
    logic [TIME_W-1:0] period;
    int                k;
    beep = BEEP_NONE;
    // advance hold timers and debounce each level
    for (k = 0; k < NUM_BTN; k++) begin
      if (hold_on[k] && hold_cnt[k] != CNT_MAX) hold_cnt[k] = hold_cnt[k] + 1'b1;
      if (lv[k] != last_lv[k]) stable_cnt[k] = '0;
      else if (stable_cnt[k] != DEB_MAX) stable_cnt[k] = stable_cnt[k] + 1'b1;
      if (stable_cnt[k] > deb_ticks || stable_cnt[k] == DEB_MAX) btn_down[k] = ~lv[k];
      last_lv[k] = lv[k];
    end
    if (blink_cnt != CNT_MAX) blink_cnt = blink_cnt + 1'b1;

    case (mode_q)
      MODE_OFF: begin
        if (hold_finished(BTN_START, start_hold)) begin
          beep        = BEEP_ONE;
          mode_q      = MODE_RUN;
          colour_q    = COL_GREEN;
          start_blink = 1'b0;
        end else begin
          start_blink = btn_down[BTN_START] && hold_on[BTN_START];
          if (!btn_down[BTN_START]) colour_q = COL_RED;
        end
      end
      MODE_RUN: begin
        if (hold_finished(BTN_STOP, start_hold)) begin
          beep       = BEEP_TWO;
          mode_q     = MODE_OFF;
          colour_q   = COL_RED;
          stop_blink = 1'b0;
        end else begin
          stop_blink = btn_down[BTN_STOP] && hold_on[BTN_STOP];
          if (!btn_down[BTN_STOP]) colour_q = COL_GREEN;
        end
        // fault wins even over a stop that completed this tick
        if (btn_down[BTN_FAULT]) begin
          beep       = BEEP_THREE;
          fault_flag = 1'b1;
          mode_q     = MODE_FAULT;
          fast_sel   = 1'b1;
          blink_cnt  = '0;
          led_lit    = 1'b0;
          clearing   = 1'b0;
        end
      end
      MODE_FAULT: begin
        if (hold_finished(BTN_FAULT, clear_hold)) begin
          beep       = BEEP_TWO;
          fault_flag = 1'b0;
          mode_q     = MODE_OFF;
          colour_q   = COL_RED;
          clearing   = 1'b0;
        end else begin
          clearing = btn_down[BTN_FAULT] && hold_on[BTN_FAULT];
          fast_sel = ~clearing;
        end
      end
      default: ;
    endcase

    blink = (mode_q == MODE_FAULT) || (mode_q == MODE_OFF && start_blink) ||
            (mode_q == MODE_RUN && stop_blink);
    if (blink || clearing) begin
      period = fast_sel ? fast_blink : slow_blink;
      if (blink_cnt >= period) begin
        blink_cnt = '0;
        if (led_lit) colour_q = COL_OFF;
        else colour_q = (mode_q == MODE_FAULT) ? COL_RED : COL_YELLOW;
        led_lit = ~led_lit;
      end
    end

    r.motor_on    = (mode_q == MODE_RUN);
    r.led_colour  = colour_q;
    r.beep        = beep;
    r.mode        = mode_q;
    r.fault_saved = fault_flag;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks   = DEBOUNCE_DEF;
      start_hold  = START_HOLD_DEF;
      clear_hold  = CLEAR_HOLD_DEF;
      slow_blink  = SLOW_BLINK_DEF;
      fast_blink  = FAST_BLINK_DEF;
      mode_q      = MODE_OFF;
      colour_q    = COL_RED;
      last_lv     = '1;
      btn_down    = '0;
      hold_on     = '0;
      for (b = 0; b < NUM_BTN; b++) begin
        stable_cnt[b] = '0;
        hold_cnt[b]   = '0;
      end
      blink_cnt   = '0;
      led_lit     = 1'b0;
      start_blink = 1'b0;
      stop_blink  = 1'b0;
      clearing    = 1'b0;
      fast_sel    = 1'b0;
      fault_flag  = 1'b0;
      expected_results.delete();
      results_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DEBOUNCE:   deb_ticks  = cfg_data_i[DEB_W-1:0];
          REG_START_HOLD: start_hold = cfg_data_i[TIME_W-1:0];
          REG_CLEAR_HOLD: clear_hold = cfg_data_i[TIME_W-1:0];
          REG_SLOW_BLINK: slow_blink = cfg_data_i[TIME_W-1:0];
          REG_FAST_BLINK: fast_blink = cfg_data_i[TIME_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(predict_tick({fault_level_i, stop_level_i, start_level_i}));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with no item outstanding");
        end else begin
          want = expected_results.pop_front();
          compare_field("motor_on", int'(motor_on_i), int'(want.motor_on));
          compare_field("led_colour", int'(led_colour_i), int'(want.led_colour));
          compare_field("beep_pattern", int'(beep_pattern_i), int'(want.beep));
          compare_field("mode", int'(mode_i), int'(want.mode));
          compare_field("fault_saved", int'(fault_saved_i), int'(want.fault_saved));
        end
        results_seen++;
      end
      results_pending_o <= expected_results.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Stimulus, clock, reset and verdict for the motor start/stop/fault controller.
`timescale 1ns / 100ps

module tb_top;
  import mssfc_pkg::*;

  // button levels as {fault, stop, start}, 0 means pressed
  localparam logic [2:0] LV_IDLE       = 3'b111;
  localparam logic [2:0] LV_START      = 3'b110;
  localparam logic [2:0] LV_STOP       = 3'b101;
  localparam logic [2:0] LV_START_STOP = 3'b100;
  localparam logic [2:0] LV_FAULT      = 3'b011;
  localparam logic [2:0] LV_STOP_FAULT = 3'b001;
  localparam logic [2:0] LV_ALL        = 3'b000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int NUM_PHASES   = 8;
  localparam int PHASE_TICKS  = 220;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 4;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  start_level_i = 1'b1;
  logic                  stop_level_i  = 1'b1;
  logic                  fault_level_i = 1'b1;
  logic                  out_ready_i   = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_ready_o;
  logic                  out_valid_o;
  logic                  motor_on_o;
  logic [1:0]            led_colour_o;
  logic [1:0]            beep_pattern_o;
  logic [1:0]            mode_o;
  logic                  fault_saved_o;
  logic                  cfg_ready_o;

  int   mismatches;
  int   results_pending;
  int   stall_cycles = 0;
  int   ticks_sent   = 0;
  logic steady_run   = 1'b0;
  int   cur_debounce;
  int   cur_start_hold;
  int   cur_clear_hold;

  motor_start_stop_fault_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .start_level_i (start_level_i),
    .stop_level_i  (stop_level_i),
    .fault_level_i (fault_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .motor_on_o    (motor_on_o),
    .led_colour_o  (led_colour_o),
    .beep_pattern_o(beep_pattern_o),
    .mode_o        (mode_o),
    .fault_saved_o (fault_saved_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  motor_ctrl_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .start_level_i    (start_level_i),
    .stop_level_i     (stop_level_i),
    .fault_level_i    (fault_level_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .motor_on_i       (motor_on_o),
    .led_colour_i     (led_colour_o),
    .beep_pattern_i   (beep_pattern_o),
    .mode_i           (mode_o),
    .fault_saved_i    (fault_saved_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .results_pending_o(results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady_run || ($urandom_range(0, 99) >= 33);
  end

  // end the run when no channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_tick(input logic [2:0] lv);
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 33) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    start_level_i <= lv[BTN_START];
    stop_level_i  <= lv[BTN_STOP];
    fault_level_i <= lv[BTN_FAULT];
    do @(posedge clk_i); while (!in_ready_o);
    ticks_sent++;
  endtask

  task automatic send_run(input logic [2:0] lv, input int n);
    repeat (n) send_tick(lv);
  endtask

  // hold length around the point where a hold of need ticks completes
  function automatic int hold_len(input int need);
    int n;
    n = cur_debounce + need + int'($urandom_range(0, 8)) - 2;
    return (n < 1) ? 1 : n;
  endfunction

  // drop valid, wait for every predicted result, then let the block settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_settings(input int deb, input int st, input int cl, input int sl,
                               input int fa);
    // upper data bits on the debounce write must be ignored
    write_reg(REG_DEBOUNCE, CFG_DATA_W'(($urandom_range(0, 255) << 8) | deb));
    write_reg(REG_START_HOLD, CFG_DATA_W'(st));
    write_reg(REG_CLEAR_HOLD, CFG_DATA_W'(cl));
    write_reg(REG_SLOW_BLINK, CFG_DATA_W'(sl));
    write_reg(REG_FAST_BLINK, CFG_DATA_W'(fa));
    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
              CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_valid_i    <= 1'b0;
    cur_debounce   = deb;
    cur_start_hold = st;
    cur_clear_hold = cl;
  endtask

  // mostly full start / run / stop-or-fault / clear cycles, some noise
  task automatic run_motor_cycle();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      send_run(LV_IDLE, $urandom_range(0, 4));
      send_run(LV_START, hold_len(cur_start_hold));
      send_run(LV_IDLE, $urandom_range(1, cur_debounce + 4));
      case ($urandom_range(0, 2))
        0: send_run(LV_STOP, hold_len(cur_start_hold));
        1: begin
          send_run(LV_FAULT, cur_debounce + $urandom_range(1, 3));
          send_run(LV_IDLE, $urandom_range(0, 3));
          send_run(LV_FAULT, hold_len(cur_clear_hold));
        end
        default: begin
          send_run(LV_STOP, $urandom_range(0, cur_start_hold + cur_debounce));
          send_run(LV_STOP_FAULT, hold_len(cur_clear_hold));
        end
      endcase
    end else if (pick < 9) begin
      repeat ($urandom_range(5, 30)) send_tick(3'($urandom_range(0, 7)));
    end else begin
      repeat ($urandom_range(2, 8)) begin
        send_run(3'($urandom_range(0, 7)),
                 $urandom_range(1, 2 * cur_debounce + cur_start_hold + 2));
      end
    end
  endtask

  initial begin
    int phase;
    int phase_first;
    logic paused;
    paused = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all buttons pressed, all released, stop with fault
    send_tick(LV_ALL);
    send_tick(LV_IDLE);
    send_tick(LV_STOP_FAULT);
    drain_results();

    // short times, zero slow period so a hold toggles the LED every tick
    load_settings(0, 2, 3, 0, 1);
    send_run(LV_START, 4);
    // fault latched while a stop hold is under way, then cleared with stop held
    send_tick(LV_STOP);
    send_run(LV_STOP_FAULT, 2);
    send_run(LV_STOP_FAULT, 4);
    // the stale stop hold acts on the first running tick
    send_run(LV_START_STOP, 5);
    // stop completes in the same tick the fault press is accepted
    send_run(LV_START, 4);
    send_run(LV_STOP, 2);
    send_run(LV_STOP_FAULT, 2);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase)
        1: load_settings(255, 65535, 65535, 65535, 65535);
        2: load_settings(0, 0, 0, 0, 0);
        6: load_settings($urandom_range(10, 40), $urandom_range(20, 60),
                         $urandom_range(20, 60), $urandom_range(2, 30),
                         $urandom_range(1, 15));
        default: load_settings($urandom_range(0, 5), $urandom_range(0, 20),
                               $urandom_range(0, 25), $urandom_range(0, 10),
                               $urandom_range(0, 5));
      endcase
      steady_run <= (phase == 3);
      phase_first = ticks_sent;
      if (phase == 1) begin
        // long press reaches the saturated debounce count
        send_run(LV_START, 300);
        repeat (20) send_tick(3'($urandom_range(0, 7)));
      end else begin
        while (ticks_sent - phase_first < PHASE_TICKS) begin
          run_motor_cycle();
          if (phase == 5 && !paused && ticks_sent - phase_first >= PHASE_TICKS / 2) begin
            drain_results();
            paused = 1'b1;
          end
        end
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
